FILE: rtl/core/aes_cbc_cipher_assert.svh
// ----------------------------------------------------------------------------
// AES-CBC assertion macros
// Concurrent check macros for the AES-CBC block; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef AES_CBC_CIPHER_ASSERT_SVH
`define AES_CBC_CIPHER_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk_i and idle during reset.
`define ACC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk_i and idle during reset.
`define ACC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ACC_ASSERT_NOW(label, ante, cons, msg)
`define ACC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: rtl/core/acc_pkg.sv
// ----------------------------------------------------------------------------
// AES-CBC package
// Shared types, register indexes, S-box tables and round functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package acc_pkg;

  localparam int unsigned RkWords = 60;

  localparam logic [2:0] CFG_KEY_WORD_0 = 3'd0;
  localparam logic [2:0] CFG_KEY_WORD_1 = 3'd1;
  localparam logic [2:0] CFG_KEY_WORD_2 = 3'd2;
  localparam logic [2:0] CFG_KEY_WORD_3 = 3'd3;
  localparam logic [2:0] CFG_KEY_SIZE   = 3'd4;
  localparam logic [2:0] CFG_DIRECTION  = 3'd5;
  localparam logic [2:0] CFG_IV_HIGH    = 3'd6;
  localparam logic [2:0] CFG_IV_LOW     = 3'd7;

  localparam logic [1:0] KEY_SIZE_128 = 2'd0;
  localparam logic [1:0] KEY_SIZE_192 = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY,
    ST_LAUNCH,
    ST_RUN
  } acc_state_e;

  typedef enum logic [1:0] {
    KS_IDLE,
    KS_LOAD,
    KS_EXP
  } acc_ks_state_e;

  typedef struct packed {
    logic       start;
    logic [1:0] size;
  } acc_ks_ctl_t;

  typedef struct packed {
    logic       busy;
    logic [3:0] rounds;
  } acc_ks_sts_t;

  typedef struct packed {
    logic       start;
    logic       decrypt;
    logic [3:0] rounds;
  } acc_cph_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // The state keeps byte 0 in the top bits; column c holds bytes 4c to 4c+3.
  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    int unsigned  src;
    o = '0;
    for (int unsigned c = 0; c < 4; c++) begin
      for (int unsigned r = 0; r < 4; r++) begin
        src = inv ? (r + 4 * ((c + 4 - r) & 3)) : (r + 4 * ((c + r) & 3));
        o[127 - 8 * (r + 4 * c) -: 8] = s[127 - 8 * src -: 8];
      end
    end
    return o;
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] a);
    logic [7:0] a0, a1, a2, a3;
    a0 = a[31:24];
    a1 = a[23:16];
    a2 = a[15:8];
    a3 = a[7:0];
    return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
            xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] a);
    logic [7:0] x [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    logic [7:0] x2, x4, x8;
    for (int unsigned k = 0; k < 4; k++) begin
      x[k]   = a[31 - 8 * k -: 8];
      x2     = xtime(x[k]);
      x4     = xtime(x2);
      x8     = xtime(x4);
      m9[k]  = x8 ^ x[k];
      m11[k] = x8 ^ x2 ^ x[k];
      m13[k] = x8 ^ x4 ^ x[k];
      m14[k] = x8 ^ x4 ^ x2;
    end
    return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
            m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
            m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
            m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    o = '0;
    for (int unsigned c = 0; c < 4; c++) begin
      o[127 - 32 * c -: 32] = inv ? inv_mix_col(s[127 - 32 * c -: 32])
                                  : mix_col(s[127 - 32 * c -: 32]);
    end
    return o;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/acc_key_sched.sv
// ----------------------------------------------------------------------------
// AES key schedule
// Expands the key into the round key memory, one S-box byte per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acc_key_sched (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire acc_pkg::acc_ks_ctl_t ctl_i,
  input  wire logic [255:0]        key_i,
  input  wire logic [5:0]          rd_addr_i,
  output logic [31:0]              rd_data_o,
  output acc_pkg::acc_ks_sts_t     sts_o
);
  import acc_pkg::*;

  logic [31:0]   mem [RkWords];
  logic [31:0]   rd_q;

  acc_ks_state_e state_q, state_d;
  logic [5:0]    idx_q;
  logic [1:0]    sub_cnt_q;
  logic [2:0]    kmod_q;
  logic [3:0]    nk_q;
  logic [3:0]    nr_q;
  logic [7:0]    rcon_q;
  logic [23:0]   sub_q;
  logic [31:0]   win_q [8];

  logic [31:0]   key_words [8];
  logic [3:0]    nk_new;
  logic [31:0]   temp;
  logic [7:0]    sel_byte;
  logic [7:0]    sub_byte;
  logic [31:0]   sub_word;
  logic [31:0]   mix_term;
  logic [2:0]    far_idx;
  logic [31:0]   exp_word;
  logic          we;
  logic [31:0]   wdata;
  logic          kmod_wrap;

  always_comb begin
    for (int unsigned k = 0; k < 8; k++) begin
      key_words[k] = key_i[255 - 32 * k -: 32];
    end
  end

  always_comb begin
    if (ctl_i.size == KEY_SIZE_128) begin
      nk_new = 4'd4;
    end else if (ctl_i.size == KEY_SIZE_192) begin
      nk_new = 4'd6;
    end else begin
      nk_new = 4'd8;
    end
  end

  // Every expanded word steps through the four bytes of temp, one S-box lookup each.
  always_comb begin
    temp = (kmod_q == 3'd0) ? {win_q[0][23:0], win_q[0][31:24]} : win_q[0];
    unique case (sub_cnt_q)
      2'd0:    sel_byte = temp[31:24];
      2'd1:    sel_byte = temp[23:16];
      2'd2:    sel_byte = temp[15:8];
      default: sel_byte = temp[7:0];
    endcase
    sub_byte = SBOX[sel_byte];
    sub_word = {sub_q, sub_byte};
    if (kmod_q == 3'd0) begin
      mix_term = sub_word ^ {rcon_q, 24'h000000};
    end else if (nk_q == 4'd8 && kmod_q == 3'd4) begin
      mix_term = sub_word;
    end else begin
      mix_term = win_q[0];
    end
    far_idx   = 3'(nk_q - 4'd1);
    exp_word  = win_q[far_idx] ^ mix_term;
    kmod_wrap = ({1'b0, kmod_q} == nk_q - 4'd1);
    we        = (state_q == KS_LOAD) || (state_q == KS_EXP && sub_cnt_q == 2'd3);
    wdata     = (state_q == KS_LOAD) ? key_words[idx_q[2:0]] : exp_word;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      KS_IDLE: begin
        if (ctl_i.start) begin
          state_d = KS_LOAD;
        end
      end
      KS_LOAD: begin
        if (idx_q == {2'b00, nk_q - 4'd1}) begin
          state_d = KS_EXP;
        end
      end
      KS_EXP: begin
        if (sub_cnt_q == 2'd3 && idx_q == {nr_q, 2'b11}) begin
          state_d = KS_IDLE;
        end
      end
      default: state_d = KS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= KS_IDLE;
      idx_q     <= '0;
      sub_cnt_q <= '0;
      kmod_q    <= '0;
      nk_q      <= 4'd4;
      nr_q      <= 4'd10;
      rcon_q    <= 8'h01;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        KS_IDLE: begin
          if (ctl_i.start) begin
            idx_q <= '0;
            nk_q  <= nk_new;
            nr_q  <= nk_new + 4'd6;
          end
        end
        KS_LOAD: begin
          idx_q     <= idx_q + 6'd1;
          kmod_q    <= '0;
          rcon_q    <= 8'h01;
          sub_cnt_q <= '0;
        end
        KS_EXP: begin
          sub_cnt_q <= sub_cnt_q + 2'd1;
          if (sub_cnt_q == 2'd3) begin
            idx_q  <= idx_q + 6'd1;
            kmod_q <= kmod_wrap ? 3'd0 : kmod_q + 3'd1;
            if (kmod_q == 3'd0) begin
              rcon_q <= xtime(rcon_q);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == KS_EXP && sub_cnt_q != 2'd3) begin
      sub_q <= {sub_q[15:0], sub_byte};
    end
    if (we) begin
      win_q[0] <= wdata;
      for (int unsigned k = 1; k < 8; k++) begin
        win_q[k] <= win_q[k - 1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[idx_q] <= wdata;
    end
    rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o    = rd_q;
  assign sts_o.busy   = (state_q != KS_IDLE);
  assign sts_o.rounds = nr_q;

endmodule

`default_nettype wire

FILE: rtl/core/acc_cipher_core.sv
// ----------------------------------------------------------------------------
// AES cipher core
// Byte-serial rounds: one S-box byte per cycle, row and column mixing at the
// end of each round after the first; the last round skips column mixing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acc_cipher_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire acc_pkg::acc_cph_ctl_t ctl_i,
  input  wire logic [127:0]         block_i,
  output logic [5:0]                rk_addr_o,
  input  wire logic [31:0]          rk_data_i,
  output logic [127:0]              result_o,
  output logic                      done_o
);
  import acc_pkg::*;

  logic         busy_q;
  logic         done_q;
  logic [3:0]   byte_q;
  logic [3:0]   rnd_q;
  logic [127:0] st_q;
  logic [127:0] kb_q;
  logic         dec_q;
  logic [3:0]   nr_q;

  logic [7:0]   sub_in;
  logic [7:0]   sub_out;
  logic [127:0] shifted;
  logic         last_rnd;
  logic [127:0] enc_mix;
  logic [127:0] dec_ark;
  logic [127:0] round_out;
  logic [3:0]   key_rnd;

  always_comb begin
    sub_in   = st_q[127:120];
    sub_out  = dec_q ? INV_SBOX[sub_in] : SBOX[sub_in];
    // The opening key addition just rotates the state once around.
    shifted  = {st_q[119:0], (rnd_q == 4'd0) ? sub_in : sub_out};
    last_rnd = (rnd_q == nr_q);
    enc_mix  = last_rnd ? shift_rows(shifted, 1'b0)
                        : mix_columns(shift_rows(shifted, 1'b0), 1'b0);
    dec_ark  = shift_rows(shifted, 1'b1) ^ kb_q;
    if (rnd_q == 4'd0) begin
      round_out = shifted ^ kb_q;
    end else if (dec_q) begin
      round_out = last_rnd ? dec_ark : mix_columns(dec_ark, 1'b1);
    end else begin
      round_out = enc_mix ^ kb_q;
    end
    key_rnd   = dec_q ? nr_q - rnd_q : rnd_q;
    rk_addr_o = {key_rnd, byte_q[1:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      byte_q <= '0;
      rnd_q  <= '0;
    end else if (ctl_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      byte_q <= '0;
      rnd_q  <= '0;
    end else if (busy_q) begin
      byte_q <= byte_q + 4'd1;
      if (byte_q == 4'd15) begin
        if (last_rnd) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          rnd_q <= rnd_q + 4'd1;
        end
      end
    end
  end

  // Round key words arrive in the cycle after their address, in the first
  // cycles of each round, and are used at its last byte.
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      st_q  <= block_i;
      dec_q <= ctl_i.decrypt;
      nr_q  <= ctl_i.rounds;
    end else if (busy_q) begin
      st_q <= (byte_q == 4'd15) ? round_out : shifted;
      if (byte_q >= 4'd1 && byte_q <= 4'd4) begin
        kb_q <= {kb_q[95:0], rk_data_i};
      end
    end
  end

  assign result_o = st_q;
  assign done_o   = done_q;

endmodule

`default_nettype wire

FILE: rtl/core/aes_cbc_cipher.sv
// AES in CBC mode for 128, 192 and 256-bit keys, one 128-bit word in and one
// 128-bit word out per item. A word with first_block set reloads the chaining
// vector from the IV registers and expands the key registers into the round
// key memory before it is processed; the key schedule performs that expansion
// with one S-box lookup per cycle. The cipher itself runs Nr + 1 rounds of
// key addition, one state byte per cycle and through the S-box in all but
// the first, with accept, launch and hand-off states around them. One word is
// in flight at a time; the output register lets the next word be accepted
// while a result waits. Key, size and IV changes take effect at the next
// first block, direction at the next word.
`timescale 1ns / 1ps
`default_nettype none
`include "aes_cbc_cipher_assert.svh"

// ----------------------------------------------------------------------------
// AES-CBC cipher
// Top level: configuration registers, chaining vector, control and output.
// ----------------------------------------------------------------------------
module aes_cbc_cipher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] block_high_i,
  input  wire logic [63:0] block_low_i,
  input  wire logic        first_block_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      result_high_o,
  output logic [63:0]      result_low_o
);
  import acc_pkg::*;

  logic [63:0]  key0_q, key1_q, key2_q, key3_q;
  logic [1:0]   key_size_q;
  logic         dir_q;
  logic [63:0]  iv_high_q, iv_low_q;

  acc_state_e   state_q, state_d;
  logic [127:0] cv_q;
  logic [127:0] in_q;
  logic         blk_dec_q;
  logic         out_valid_q;
  logic [127:0] out_q;

  acc_ks_ctl_t  ks_ctl;
  acc_ks_sts_t  ks_sts;
  acc_cph_ctl_t cph_ctl;
  logic [5:0]   rk_addr;
  logic [31:0]  rk_data;
  logic [127:0] cph_result;
  logic         cph_done;

  logic         in_fire;
  logic         finish;
  logic [127:0] result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q     <= '0;
      key1_q     <= '0;
      key2_q     <= '0;
      key3_q     <= '0;
      key_size_q <= '0;
      dir_q      <= 1'b0;
      iv_high_q  <= '0;
      iv_low_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY_WORD_0: key0_q <= cfg_data_i;
        CFG_KEY_WORD_1: key1_q <= cfg_data_i;
        CFG_KEY_WORD_2: key2_q <= cfg_data_i;
        CFG_KEY_WORD_3: key3_q <= cfg_data_i;
        CFG_KEY_SIZE:   key_size_q <= cfg_data_i[1:0];
        CFG_DIRECTION:  dir_q <= cfg_data_i[0];
        CFG_IV_HIGH:    iv_high_q <= cfg_data_i;
        CFG_IV_LOW:     iv_low_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign finish     = (state_q == ST_RUN) && cph_done && (!out_valid_q || out_ready_i);
  assign result     = blk_dec_q ? (cph_result ^ cv_q) : cph_result;

  always_comb begin
    state_d         = state_q;
    ks_ctl.start    = 1'b0;
    ks_ctl.size     = key_size_q;
    cph_ctl.start   = 1'b0;
    cph_ctl.decrypt = blk_dec_q;
    cph_ctl.rounds  = ks_sts.rounds;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          ks_ctl.start = first_block_i;
          state_d      = first_block_i ? ST_KEY : ST_LAUNCH;
        end
      end
      ST_KEY: begin
        if (!ks_sts.busy) begin
          state_d = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        cph_ctl.start = 1'b1;
        state_d       = ST_RUN;
      end
      ST_RUN: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cv_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire && first_block_i) begin
        cv_q <= {iv_high_q, iv_low_q};
      end else if (finish) begin
        // Decryption chains the incoming ciphertext, encryption the outgoing.
        cv_q <= blk_dec_q ? in_q : cph_result;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q      <= {block_high_i, block_low_i};
      blk_dec_q <= dir_q;
    end
    if (finish) begin
      out_q <= result;
    end
  end

  acc_key_sched u_key_sched (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ks_ctl),
    .key_i     ({key0_q, key1_q, key2_q, key3_q}),
    .rd_addr_i (rk_addr),
    .rd_data_o (rk_data),
    .sts_o     (ks_sts)
  );

  acc_cipher_core u_cipher_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (cph_ctl),
    .block_i   (blk_dec_q ? in_q : (in_q ^ cv_q)),
    .rk_addr_o (rk_addr),
    .rk_data_i (rk_data),
    .result_o  (cph_result),
    .done_o    (cph_done)
  );

  assign out_valid_o   = out_valid_q;
  assign result_high_o = out_q[127:64];
  assign result_low_o  = out_q[63:0];

  `ACC_ASSERT_NOW(a_ks_only_in_key, ks_sts.busy, state_q == ST_KEY, "key schedule busy outside key wait")
  `ACC_ASSERT_NEXT(a_first_starts_ks, in_fire && first_block_i, ks_sts.busy, "first block did not start key expansion")
  `ACC_ASSERT_NEXT(a_finish_loads_out, finish, out_valid_o && !cph_ctl.start, "finished word not presented")

endmodule

`default_nettype wire
